// ===== rtl/bcc_pkg.sv =====
// Package for the button click classifier: event codes, register indexes,
// reset values and the sequence state record. No dependencies.
package bcc_pkg;

   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned TimeoutWidth = 16;
   localparam int unsigned HitWidth     = 8;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [HitWidth-1:0] HitMax = '1;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PULL_DOWN     = 2'd0,
      CSR_CLICK_TIMEOUT = 2'd1,
      CSR_LONG_TIMEOUT  = 2'd2
   } csr_index_type;

   localparam logic                    PullDownReset     = 1'b1;
   localparam logic [TimeoutWidth-1:0] ClickTimeoutReset = 16'd250;
   localparam logic [TimeoutWidth-1:0] LongTimeoutReset  = 16'd1000;

   typedef enum logic [1:0] {
      EDGE_NONE         = 2'd0,
      EDGE_PRESS        = 2'd1,
      EDGE_RELEASE      = 2'd2,
      EDGE_LONG_RELEASE = 2'd3
   } edge_event_type;

   typedef enum logic [1:0] {
      TMO_NONE         = 2'd0,
      TMO_CLICK        = 2'd1,
      TMO_DOUBLE_CLICK = 2'd2,
      TMO_LONG_PRESS   = 2'd3
   } timeout_event_type;

   // Press sequence state carried from one transaction to the next.
   typedef struct packed {
      logic                 last_level;
      logic                 seq_active;
      logic                 held_down;
      logic [HitWidth-1:0]  hit_count;
      logic [TimeWidth-1:0] start_time;
   } seq_state_type;

   localparam seq_state_type SeqStateReset = '{
      last_level: 1'b0,
      seq_active: 1'b0,
      held_down:  1'b0,
      hit_count:  '0,
      start_time: '0
   };

   typedef struct packed {
      logic                    pull_down;
      logic [TimeoutWidth-1:0] click_timeout_ms;
      logic [TimeoutWidth-1:0] long_press_timeout_ms;
   } cfg_type;

endpackage

// ===== rtl/bcc_step.sv =====
// Next-state and event logic for one transaction: edge handling, then the
// timeout check at the same timestamp. Depends on bcc_pkg.
module bcc_step
   import bcc_pkg::*;
(
   input  seq_state_type            cur_state,
   input  cfg_type                  cfg,
   input  logic                     mode,
   input  logic                     level,
   input  logic [TimeWidth-1:0]     now_ms,
   output seq_state_type            next_state,
   output edge_event_type           edge_event,
   output timeout_event_type        timeout_event
);

   logic                 rise;
   logic                 fall;
   logic                 press;
   logic                 release_edge;
   logic [TimeWidth-1:0] rel_delta;
   logic [TimeWidth-1:0] tmo_delta;
   seq_state_type        mid_state;

   always_comb begin
      rise         = (mode == 1'b0) && !cur_state.last_level && level;
      fall         = (mode == 1'b0) && cur_state.last_level && !level;
      press        = cfg.pull_down ? rise : fall;
      release_edge = cfg.pull_down ? fall : rise;
      rel_delta    = now_ms - cur_state.start_time;

      // edge handling
      mid_state  = cur_state;
      edge_event = EDGE_NONE;
      if (press) begin
         edge_event          = EDGE_PRESS;
         mid_state.held_down = 1'b1;
         if (!cur_state.seq_active) begin
            mid_state.seq_active = 1'b1;
            mid_state.start_time = now_ms;
         end
      end else if (release_edge) begin
         if (rel_delta > {{(TimeWidth-TimeoutWidth){1'b0}}, cfg.long_press_timeout_ms}) begin
            edge_event           = EDGE_LONG_RELEASE;
            mid_state.hit_count  = '0;
            mid_state.start_time = '0;
            mid_state.seq_active = 1'b0;
            mid_state.held_down  = 1'b0;
         end else begin
            edge_event          = EDGE_RELEASE;
            mid_state.held_down = 1'b0;
            if (cur_state.hit_count != HitMax) begin
               mid_state.hit_count = cur_state.hit_count + 1'b1;
            end
         end
      end
      if (mode == 1'b0) begin
         mid_state.last_level = level;
      end

      // timeout check against the post-edge state
      tmo_delta     = now_ms - mid_state.start_time;
      next_state    = mid_state;
      timeout_event = TMO_NONE;
      if (mid_state.seq_active) begin
         if (tmo_delta >= {{(TimeWidth-TimeoutWidth){1'b0}}, cfg.long_press_timeout_ms}) begin
            if (mid_state.held_down && (mid_state.hit_count == '0)) begin
               timeout_event = TMO_LONG_PRESS;
            end
            next_state.hit_count  = '0;
            next_state.start_time = '0;
            next_state.seq_active = 1'b0;
            next_state.held_down  = 1'b0;
         end else if ((tmo_delta >= {{(TimeWidth-TimeoutWidth){1'b0}}, cfg.click_timeout_ms})
                      && !mid_state.held_down) begin
            if (mid_state.hit_count == HitWidth'(1)) begin
               timeout_event = TMO_CLICK;
            end else if (mid_state.hit_count == HitWidth'(2)) begin
               timeout_event = TMO_DOUBLE_CLICK;
            end
            next_state.hit_count  = '0;
            next_state.start_time = '0;
            next_state.seq_active = 1'b0;
            next_state.held_down  = 1'b0;
         end
      end
   end

endmodule

// ===== rtl/button_click_classifier.sv =====
// Top level of the button click classifier: input register, sequence state,
// configuration registers and result register. Depends on bcc_pkg, bcc_step.
//
// Usage:
//  - req_ channel: one transaction per button sample (req_mode 0, req_level)
//    or refresh tick (req_mode 1), each with a millisecond timestamp.
//  - rsp_ channel: exactly one result transaction per request, in order:
//    edge event, timeout event and the sequence active flag.
//  - csr_ port: write-only; index 0 pull_down, 1 click timeout, 2 long
//    press timeout. Other indexes are ignored. Write only while idle.
// A request is taken into the input register and its result into the result register.
// Throughput: one transaction per cycle while rsp_stall is low; the state update is a single pass
// through bcc_step between the input register and the result register.
// Reset: synchronous, clears both pipeline valids and the press sequence
// state, and loads the configuration defaults (pull-down, 250 ms, 1000 ms).
// Stall: when rsp_stall holds a pending result, the input register keeps
// its transaction and req_stall rises only once that register is full.
module button_click_classifier
   import bcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic                     req_level,
   input  logic [TimeWidth-1:0]     req_now_ms,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_edge_event,
   output logic [1:0]               rsp_timeout_event,
   output logic                     rsp_active,
   // configuration port
   input  logic                     csr_write,
   input  logic [CsrIdxWidth-1:0]   csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_mode_ff;
   logic                 in_level_ff;
   logic [TimeWidth-1:0] in_now_ff;

   // result register
   logic                 out_valid_ff, out_valid_in;
   edge_event_type       out_edge_ff;
   timeout_event_type    out_tmo_ff;
   logic                 out_active_ff;

   seq_state_type        state_ff, state_in;
   cfg_type              cfg_ff, cfg_in;

   edge_event_type       step_edge;
   timeout_event_type    step_tmo;

   logic                 out_ready;
   logic                 advance;
   logic                 req_take;

   // The result register frees up when empty or when its transaction leaves.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   bcc_step u_step (
      .cur_state     (state_ff),
      .cfg           (cfg_ff),
      .mode          (in_mode_ff),
      .level         (in_level_ff),
      .now_ms        (in_now_ff),
      .next_state    (state_in),
      .edge_event    (step_edge),
      .timeout_event (step_tmo)
   );

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      if (advance) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end

      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PULL_DOWN:     cfg_in.pull_down             = csr_wdata[0];
            CSR_CLICK_TIMEOUT: cfg_in.click_timeout_ms      = csr_wdata;
            CSR_LONG_TIMEOUT:  cfg_in.long_press_timeout_ms = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= SeqStateReset;
         cfg_ff       <= '{pull_down:             PullDownReset,
                           click_timeout_ms:      ClickTimeoutReset,
                           long_press_timeout_ms: LongTimeoutReset};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff  <= req_mode;
         in_level_ff <= req_level;
         in_now_ff   <= req_now_ms;
      end
      if (advance) begin
         out_edge_ff   <= step_edge;
         out_tmo_ff    <= step_tmo;
         out_active_ff <= state_in.seq_active;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_edge_event    = out_edge_ff;
   assign rsp_timeout_event = out_tmo_ff;
   assign rsp_active        = out_active_ff;

endmodule
